// ----- src/rational_arithmetic_unit_macros.svh -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_macros
// Assertion macros shared by the rational arithmetic unit modules.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau assertion failed");

`endif

// ----- src/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int ValueBits  = 32;
  localparam int QueueDepth = 2;

  typedef logic [2:0] mode_t;

  localparam mode_t ModeAdd = 3'd0;
  localparam mode_t ModeSub = 3'd1;
  localparam mode_t ModeMul = 3'd2;
  localparam mode_t ModeDiv = 3'd3;
  localparam mode_t ModePow = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZDEN   = 2'd1,
    ST_BADPOW = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    status_t            status;
  } rau_rsp_t;

  // classification handed from front to back
  typedef struct packed {
    mode_t   mode;
    status_t status;
  } rau_cls_t;

endpackage

// ----- src/rau_fifo.sv -----
// ----------------------------------------------------------------------------
// rau_fifo
// Short queue between the front and the back of the unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign ready = (count != CntW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RAU_ASSERT_NEXT(a_fifo_fill, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ----- src/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// Accepts items, splits operands into sign and magnitude, flags early errors.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int VALUE_BITS = rau_pkg::ValueBits
) (
  input  logic                          req_valid,
  output logic                          req_ready,
  input  rau_pkg::rau_req_t             req,
  output logic                          push,
  input  logic                          queue_ready,
  output rau_pkg::rau_cls_t             cls,
  output logic [4*(VALUE_BITS+1)-1:0]   ops
);

  localparam int W = VALUE_BITS;

  function automatic logic [W:0] sm(input logic [31:0] f);
    logic [W-1:0] v;
    v = f[W-1:0];
    return v[W-1] ? {1'b1, ~v + 1'b1} : {1'b0, v};
  endfunction

  logic [W:0] an, ad, bn, bd;

  assign an = sm(req.a_num);
  assign ad = sm(req.a_den);
  assign bn = sm(req.b_num);
  assign bd = sm(req.b_den);

  assign ops       = {an, ad, bn, bd};
  assign req_ready = queue_ready;
  assign push      = req_valid && queue_ready;

  always_comb begin
    cls.mode = req.mode;
    if (req.mode > rau_pkg::ModePow) begin
      cls.status = rau_pkg::ST_BADPOW;
    end else if (ad[W-1:0] == '0 || bd[W-1:0] == '0) begin
      cls.status = rau_pkg::ST_ZDEN;
    end else begin
      cls.status = rau_pkg::ST_OK;
    end
  end

endmodule

// ----- src/rau_norm.sv -----
// ----------------------------------------------------------------------------
// rau_norm
// Reduces a fraction by the gcd of its magnitudes: binary gcd steps, then
// two restoring divisions by the odd gcd part run side by side.
// ----------------------------------------------------------------------------
module rau_norm #(
  parameter int VALUE_BITS = rau_pkg::ValueBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2*VALUE_BITS-1:0]   num,
  input  logic [2*VALUE_BITS-1:0]   den,
  output logic                      done,
  output logic [2*VALUE_BITS-1:0]   num_q,
  output logic [2*VALUE_BITS-1:0]   den_q
);

  localparam int D    = 2 * VALUE_BITS;
  localparam int CntW = $clog2(D + 1);

  typedef enum logic [1:0] {N_IDLE, N_GCD, N_DIV} state_t;

  state_t          state;
  logic [D-1:0]    x, y, qn, qd, rem_n, rem_d;
  logic [CntW-1:0] cnt;
  logic [D:0]      rn_sh, rd_sh;
  logic            rn_ge, rd_ge;
  logic            done_next;

  assign rn_sh = {rem_n, qn[D-1]};
  assign rd_sh = {rem_d, qd[D-1]};
  assign rn_ge = rn_sh >= {1'b0, x};
  assign rd_ge = rd_sh >= {1'b0, x};
  assign num_q = qn;
  assign den_q = qd;

  always_comb begin
    unique case (state)
      N_IDLE:  done_next = start && (num == '0);
      N_GCD:   done_next = x[0] && y[0] && (x == y) && (x == D'(1));
      N_DIV:   done_next = (cnt == CntW'(1));
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            qn <= num;
            qd <= den;
            x  <= num;
            y  <= den;
            if (num != '0) begin
              state <= N_GCD;
            end
          end
        end
        N_GCD: begin
          // common factors of two come off the quotients directly
          if (!x[0] && !y[0]) begin
            x  <= x >> 1;
            y  <= y >> 1;
            qn <= qn >> 1;
            qd <= qd >> 1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x == y) begin
            if (x == D'(1)) begin
              state <= N_IDLE;
            end else begin
              rem_n <= '0;
              rem_d <= '0;
              cnt   <= CntW'(D);
              state <= N_DIV;
            end
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        N_DIV: begin
          rem_n <= rn_ge ? D'(rn_sh - {1'b0, x}) : rn_sh[D-1:0];
          rem_d <= rd_ge ? D'(rd_sh - {1'b0, x}) : rd_sh[D-1:0];
          qn    <= {qn[D-2:0], rn_ge};
          qd    <= {qd[D-2:0], rd_ge};
          cnt   <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// Sequencer that normalizes operands, forms the raw result with a shared
// multiplier and normalizes the result into the output register.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_back #(
  parameter int VALUE_BITS = rau_pkg::ValueBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  rau_pkg::rau_cls_t             cls,
  input  logic [4*(VALUE_BITS+1)-1:0]   ops,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output rau_pkg::rau_rsp_t             rsp
);

  localparam int W  = VALUE_BITS;
  localparam int D  = 2 * W;
  localparam int OW = 4 * (W + 1);
  localparam logic [D:0]   Cap  = (D + 1)'(1) << W;
  localparam logic [D-1:0] Half = D'(1) << (W - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_NA, B_NB, B_OP, B_M1, B_M2, B_M3, B_SUM,
    B_PN, B_PD, B_CHK, B_NR, B_OUT
  } state_t;

  state_t            state;
  rau_pkg::mode_t    mode;
  rau_pkg::status_t  st;
  logic              an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0]      an, ad, bn, bd, e;
  logic              rn_neg, rd_neg, p2_neg;
  logic [D-1:0]      rn_mag, rd_mag, p2;
  logic              norm_start, norm_start_next, norm_done;
  logic [D-1:0]      norm_num, norm_den, norm_num_q, norm_den_q;
  logic              cur_num_neg, cur_den_neg, new_num_neg, new_den_neg, fits_ok;
  logic [W:0]        mul_a;
  logic [W-1:0]      mul_b;
  logic [D:0]        mul_p;
  logic              add_sub, same_sign, rn_ge_p2, sum_neg;
  logic [D-1:0]      sum_mag;
  rau_pkg::rau_rsp_t out_next;

  function automatic logic fits(input logic neg, input logic [D-1:0] mag);
    return neg ? (mag <= Half) : (mag < Half);
  endfunction

  rau_norm #(.VALUE_BITS(W)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .num   (norm_num),
    .den   (norm_den),
    .done  (norm_done),
    .num_q (norm_num_q),
    .den_q (norm_den_q)
  );

  assign item_ready = (state == B_IDLE);
  assign add_sub    = (mode == rau_pkg::ModeAdd) || (mode == rau_pkg::ModeSub);

  always_comb begin
    case (state)
      B_NA: begin
        norm_num    = D'(an);
        norm_den    = D'(ad);
        cur_num_neg = an_neg;
        cur_den_neg = ad_neg;
      end
      B_NB: begin
        norm_num    = D'(bn);
        norm_den    = D'(bd);
        cur_num_neg = bn_neg;
        cur_den_neg = bd_neg;
      end
      default: begin
        norm_num    = rn_mag;
        norm_den    = rd_mag;
        cur_num_neg = rn_neg;
        cur_den_neg = rd_neg;
      end
    endcase
  end

  // sign moves to the numerator unless the numerator is zero
  assign new_num_neg = (norm_num_q != '0) && (cur_num_neg ^ cur_den_neg);
  assign new_den_neg = (norm_num_q == '0) && cur_den_neg;
  assign fits_ok     = fits(new_num_neg, norm_num_q) && fits(new_den_neg, norm_den_q);

  // one-cycle start pulse for the normalize unit
  always_comb begin
    case (state)
      B_IDLE:  norm_start_next = item_valid && (cls.status == rau_pkg::ST_OK);
      B_NA:    norm_start_next = norm_done && fits_ok;
      B_CHK:   norm_start_next = (rd_mag != '0);
      default: norm_start_next = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      B_M1: begin
        mul_a = (W + 1)'(an);
        mul_b = (mode == rau_pkg::ModeMul) ? bn : bd;
      end
      B_M2: begin
        mul_a = (W + 1)'(ad);
        mul_b = bn;
      end
      B_M3: begin
        mul_a = (W + 1)'(ad);
        mul_b = (mode == rau_pkg::ModeDiv) ? bn : bd;
      end
      B_PN: begin
        mul_a = rn_mag[W:0];
        mul_b = an;
      end
      B_PD: begin
        mul_a = rd_mag[W:0];
        mul_b = ad;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = (D + 1)'(mul_a) * (D + 1)'(mul_b);

  assign same_sign = (rn_neg == p2_neg);
  assign rn_ge_p2  = (rn_mag >= p2);
  assign sum_mag   = same_sign ? rn_mag + p2 : (rn_ge_p2 ? rn_mag - p2 : p2 - rn_mag);
  assign sum_neg   = ((same_sign || rn_ge_p2) ? rn_neg : p2_neg) && (sum_mag != '0);

  always_comb begin
    if (st != rau_pkg::ST_OK) begin
      out_next.result_num = '0;
      out_next.result_den = '0;
    end else begin
      out_next.result_num = rn_neg ? -32'(rn_mag[W-1:0]) : 32'(rn_mag[W-1:0]);
      out_next.result_den = rd_neg ? -32'(rd_mag[W-1:0]) : 32'(rd_mag[W-1:0]);
    end
    out_next.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      rsp_valid  <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      norm_start <= norm_start_next;
      if (rsp_valid && rsp_ready && state != B_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (item_valid) begin
            mode             <= cls.mode;
            st               <= cls.status;
            {an_neg, an}     <= ops[OW-1 -: W+1];
            {ad_neg, ad}     <= ops[3*(W+1)-1 -: W+1];
            {bn_neg, bn}     <= ops[2*(W+1)-1 -: W+1];
            {bd_neg, bd}     <= ops[W:0];
            if (cls.status != rau_pkg::ST_OK) begin
              state <= B_OUT;
            end else begin
              state <= B_NA;
            end
          end
        end
        B_NA: begin
          if (norm_done) begin
            an     <= norm_num_q[W-1:0];
            ad     <= norm_den_q[W-1:0];
            an_neg <= new_num_neg;
            ad_neg <= new_den_neg;
            if (!fits_ok) begin
              st    <= rau_pkg::ST_OVF;
              state <= B_OUT;
            end else begin
              state <= B_NB;
            end
          end
        end
        B_NB: begin
          if (norm_done) begin
            bn     <= norm_num_q[W-1:0];
            bd     <= norm_den_q[W-1:0];
            bn_neg <= new_num_neg;
            bd_neg <= new_den_neg;
            if (!fits_ok) begin
              st    <= rau_pkg::ST_OVF;
              state <= B_OUT;
            end else begin
              state <= B_OP;
            end
          end
        end
        B_OP: begin
          if (mode == rau_pkg::ModePow) begin
            if (bd_neg || bd != W'(1) || bn_neg) begin
              st    <= rau_pkg::ST_BADPOW;
              state <= B_OUT;
            end else if (bn == '0) begin
              rn_mag <= D'(1);
              rd_mag <= D'(1);
              rn_neg <= 1'b0;
              rd_neg <= 1'b0;
              state  <= B_OUT;
            end else if (an <= W'(1) && ad <= W'(1)) begin
              // bases of zero or one keep their value
              rn_mag <= D'(an);
              rd_mag <= D'(ad);
              rn_neg <= an_neg && bn[0];
              rd_neg <= ad_neg && bn[0];
              state  <= B_CHK;
            end else begin
              rn_mag <= D'(1);
              rd_mag <= D'(1);
              rn_neg <= an_neg && bn[0];
              rd_neg <= ad_neg && bn[0];
              e      <= bn;
              state  <= B_PN;
            end
          end else begin
            state <= B_M1;
          end
        end
        B_PN: begin
          rn_mag <= D'(mul_p);
          if (mul_p > Cap) begin
            st    <= rau_pkg::ST_OVF;
            state <= B_OUT;
          end else begin
            state <= B_PD;
          end
        end
        B_PD: begin
          rd_mag <= D'(mul_p);
          e      <= e - 1'b1;
          if (mul_p > Cap) begin
            st    <= rau_pkg::ST_OVF;
            state <= B_OUT;
          end else if (e == W'(1)) begin
            state <= B_CHK;
          end else begin
            state <= B_PN;
          end
        end
        B_M1: begin
          rn_mag <= D'(mul_p);
          rn_neg <= (an_neg ^ ((mode == rau_pkg::ModeMul) ? bn_neg : bd_neg))
                    && (mul_p != '0);
          state  <= add_sub ? B_M2 : B_M3;
        end
        B_M2: begin
          p2     <= D'(mul_p);
          p2_neg <= ((ad_neg ^ bn_neg) ^ (mode == rau_pkg::ModeSub)) && (mul_p != '0);
          state  <= B_M3;
        end
        B_M3: begin
          rd_mag <= D'(mul_p);
          rd_neg <= (ad_neg ^ ((mode == rau_pkg::ModeDiv) ? bn_neg : bd_neg))
                    && (mul_p != '0);
          state  <= add_sub ? B_SUM : B_CHK;
        end
        B_SUM: begin
          rn_mag <= sum_mag;
          rn_neg <= sum_neg;
          state  <= B_CHK;
        end
        B_CHK: begin
          if (rd_mag == '0) begin
            st    <= rau_pkg::ST_ZDEN;
            state <= B_OUT;
          end else begin
            state <= B_NR;
          end
        end
        B_NR: begin
          if (norm_done) begin
            rn_mag <= norm_num_q;
            rd_mag <= norm_den_q;
            rn_neg <= new_num_neg;
            rd_neg <= new_den_neg;
            st     <= fits_ok ? rau_pkg::ST_OK : rau_pkg::ST_OVF;
            state  <= B_OUT;
          end
        end
        B_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= out_next;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `RAU_ASSERT_IMPLIES(a_err_zero, clk, rst, rsp_valid && rsp.status != rau_pkg::ST_OK, rsp.result_num == '0 && rsp.result_den == '0)
  `RAU_ASSERT_IMPLIES(a_den_pos, clk, rst, rsp_valid && rsp.status == rau_pkg::ST_OK && rsp.result_num != '0, !rsp.result_den[31] && rsp.result_den != '0)
  `RAU_ASSERT_NEXT(a_pop_busy, clk, rst, item_valid && item_ready, state != B_IDLE)

endmodule

// ----- src/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide and integer power on two fractions,
// with sign moved to the numerator and gcd reduction of the result.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// req      in         req_valid/req_ready   rau_req_t (mode, a_num .. b_den)
// rsp      out        rsp_valid/rsp_ready   rau_rsp_t (result, status)
//
// one item at a time in the back end; an item with an early error goes straight
// to the output, a full one takes as long as the binary gcd steps and the
// restoring divisions of the shared normalize unit (run up to three times) plus
// up to 2*(VALUE_BITS+1) power multiplies.
// the front queue takes up to QUEUE_DEPTH items while the back is busy.
// reset is synchronous; no clearing pass; a stalled rsp holds the back end.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int VALUE_BITS  = rau_pkg::ValueBits,
  parameter int QUEUE_DEPTH = rau_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rau_pkg::rau_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rau_pkg::rau_rsp_t rsp
);

  localparam int OpsW  = 4 * (VALUE_BITS + 1);
  localparam int ItemW = $bits(rau_pkg::rau_cls_t) + OpsW;

  logic                push, queue_ready, item_valid, item_ready;
  rau_pkg::rau_cls_t   front_cls, back_cls;
  logic [OpsW-1:0]     front_ops, back_ops;
  logic [ItemW-1:0]    item_rdata;

  rau_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .push        (push),
    .queue_ready (queue_ready),
    .cls         (front_cls),
    .ops         (front_ops)
  );

  rau_fifo #(.WIDTH(ItemW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({front_cls, front_ops}),
    .ready (queue_ready),
    .pop   (item_valid && item_ready),
    .valid (item_valid),
    .rdata (item_rdata)
  );

  assign back_cls = item_rdata[ItemW-1 -: $bits(rau_pkg::rau_cls_t)];
  assign back_ops = item_rdata[OpsW-1:0];

  rau_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cls        (back_cls),
    .ops        (back_ops),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

// ----- test/tb_rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives fraction operations into the rational arithmetic unit, predicts each
// reduced result with exact wide arithmetic and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class rau_scoreboard;
  rau_pkg::rau_rsp_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  static function bit fits32(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  // reduce n/d with the sign moved to n; zero numerator left as formed
  static function rau_pkg::status_t reduce(inout longint n, inout longint d);
    logic [63:0] g, an, ad;
    bit neg;
    if (d == 0) return rau_pkg::ST_ZDEN;
    if (n != 0) begin
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      g = gcd64(an, ad);
      an = an / g;
      ad = ad / g;
      n = neg ? -longint'(an) : longint'(an);
      d = longint'(ad);
    end
    if (!fits32(n) || !fits32(d)) return rau_pkg::ST_OVF;
    return rau_pkg::ST_OK;
  endfunction

  static function bit power_mag(logic [63:0] b, logic [63:0] e, output logic [63:0] r);
    logic [63:0] i;
    r = 1;
    if (b <= 1) begin
      r = b;
      return 1;
    end
    for (i = 0; i < e; i++) begin
      r = r * b;
      if (r > 64'h1_0000_0000) return 0;
    end
    return 1;
  endfunction

  static function rau_pkg::rau_rsp_t compute(rau_pkg::rau_req_t q);
    rau_pkg::rau_rsp_t r;
    rau_pkg::status_t st;
    longint an, ad, bn, bd, rn, rd;
    logic [63:0] pn, pd;
    bit odd;
    an = q.a_num; ad = q.a_den; bn = q.b_num; bd = q.b_den;
    rn = 0; rd = 0;
    st = rau_pkg::ST_OK;
    if (q.mode > rau_pkg::ModePow) st = rau_pkg::ST_BADPOW;
    if (st == rau_pkg::ST_OK && (ad == 0 || bd == 0)) st = rau_pkg::ST_ZDEN;
    if (st == rau_pkg::ST_OK) st = reduce(an, ad);
    if (st == rau_pkg::ST_OK) st = reduce(bn, bd);
    if (st == rau_pkg::ST_OK) begin
      if (q.mode == rau_pkg::ModePow) begin
        if (bd != 1 || bn < 0) begin
          st = rau_pkg::ST_BADPOW;
        end else if (bn == 0) begin
          rn = 1;
          rd = 1;
        end else begin
          odd = bn[0];
          if (!power_mag((an < 0) ? -an : an, bn, pn) ||
              !power_mag((ad < 0) ? -ad : ad, bn, pd)) begin
            st = rau_pkg::ST_OVF;
          end else begin
            rn = (an < 0 && odd) ? -longint'(pn) : longint'(pn);
            rd = (ad < 0 && odd) ? -longint'(pd) : longint'(pd);
            st = reduce(rn, rd);
          end
        end
      end else begin
        case (q.mode)
          rau_pkg::ModeAdd: begin rn = an * bd + ad * bn; rd = ad * bd; end
          rau_pkg::ModeSub: begin rn = an * bd - ad * bn; rd = ad * bd; end
          rau_pkg::ModeMul: begin rn = an * bn; rd = ad * bd; end
          default: begin rn = an * bd; rd = ad * bn; end
        endcase
        st = reduce(rn, rd);
      end
    end
    if (st != rau_pkg::ST_OK) begin
      rn = 0;
      rd = 0;
    end
    r.result_num = rn[31:0];
    r.result_den = rd[31:0];
    r.status = st;
    return r;
  endfunction

  function void note_request(rau_pkg::rau_req_t q);
    pending.push_back(compute(q));
  endfunction

  function void check_result(rau_pkg::rau_rsp_t got);
    rau_pkg::rau_rsp_t want;
    if (pending.size() == 0) begin
      report("unexpected item", got.result_num, '0);
      return;
    end
    want = pending.pop_front();
    if (got.result_num !== want.result_num) report("result_num", got.result_num, want.result_num);
    if (got.result_den !== want.result_den) report("result_den", got.result_den, want.result_den);
    if (got.status !== want.status) report("status", got.status, want.status);
  endfunction

  function void report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    errors++;
  endfunction
endclass

module tb_rational_arithmetic_unit;

  localparam int StallLimit = 20000;
  localparam rau_pkg::mode_t ModeBadLo = 3'd5;
  localparam rau_pkg::mode_t ModeBadHi = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  rau_pkg::rau_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rau_pkg::rau_rsp_t rsp;

  rau_scoreboard sb = new();
  int idle_cycles = 0;

  rational_arithmetic_unit DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 | $urandom_range(0, 1);
      1: return 32'h7fff_ffff - $urandom_range(0, 1);
      2: return $urandom_range(0, 1);
      3: return -$urandom_range(1, 2);
      4: return $urandom;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  // called at a falling edge; leaves valid high when the next item follows at once
  task automatic send(rau_pkg::mode_t m, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    int n;
    req_valid <= 1;
    req <= '{mode: m, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    n = gap_len();
    if (n > 0) begin
      req_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  // input accept and result check monitor, with a stall limit
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("tb_rational_arithmetic_unit: FAIL");
        $finish;
      end
    end
  end

  // random receiver stall, sometimes none for a stretch
  initial begin
    int n;
    @(negedge clk);
    forever begin
      rsp_ready <= 1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        rsp_ready <= 0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    logic [31:0] bn, bd;
    rau_pkg::mode_t m;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed cases
    send(rau_pkg::ModeAdd, 1, 2, 1, 3);
    send(rau_pkg::ModeSub, 1, 2, 1, 2);
    send(rau_pkg::ModeMul, -3, 4, 8, -9);
    send(rau_pkg::ModeDiv, 1, 2, 0, 5);
    send(rau_pkg::ModeDiv, 32'h8000_0000, 1, 1, 32'h8000_0000);
    send(rau_pkg::ModeAdd, 1, 0, 1, 1);
    send(rau_pkg::ModeAdd, 32'h8000_0000, -1, 1, 1);
    send(rau_pkg::ModeAdd, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send(rau_pkg::ModeMul, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send(rau_pkg::ModePow, 2, 3, 5, 1);
    send(rau_pkg::ModePow, -2, 1, 31, 1);
    send(rau_pkg::ModePow, 2, 1, 31, 1);
    send(rau_pkg::ModePow, 0, 7, 0, 1);
    send(rau_pkg::ModePow, 0, -3, 3, 1);
    send(rau_pkg::ModePow, 2, 1, -1, 1);
    send(rau_pkg::ModePow, 2, 1, 1, 2);
    send(rau_pkg::ModePow, 3, 1, 4, 2);
    send(rau_pkg::ModePow, -1, 1, 32'h7fff_ffff, 1);
    send(ModeBadLo, 1, 1, 1, 1);
    send(ModeBadHi, 1, 0, 1, 1);
    send(rau_pkg::ModeSub, 0, -5, 0, 3);
    send(rau_pkg::ModeMul, 0, -4, 3, 2);
    send(rau_pkg::ModeDiv, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    repeat (850) begin
      m = ($urandom_range(0, 19) == 0) ? rau_pkg::mode_t'($urandom_range(5, 7))
                                       : rau_pkg::mode_t'($urandom_range(0, 4));
      bn = pick_value();
      bd = pick_value();
      if (m == rau_pkg::ModePow && $urandom_range(0, 3) != 0) begin
        bn = $urandom_range(0, 12);
        bd = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : 1;
        if ($urandom_range(0, 3) == 0) bd = bd * 3;
        if (bd != 1 && bd != 32'hffff_ffff) bn = bn * 3;
      end
      send(m, pick_value(), pick_value(), bn, bd);
    end
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("tb_rational_arithmetic_unit: PASS");
    else $display("tb_rational_arithmetic_unit: FAIL");
    $finish;
  end
endmodule
